### hdl/fixed_column_line_lexer_assert.svh
// ----------------------------------------------------------------------------
// Fixed-column line lexer assertion macros
// Shared property forms for the lexer checks, clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_COLUMN_LINE_LEXER_ASSERT_SVH
`define FIXED_COLUMN_LINE_LEXER_ASSERT_SVH

// same-cycle implication
`define FCLL_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fixed_column_line_lexer: check failed");

// next-cycle implication
`define FCLL_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fixed_column_line_lexer: check failed");

`endif

### hdl/fcll_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-column line lexer package
// Item types, result kinds, status and section codes, character constants.
// ----------------------------------------------------------------------------
package fcll_pkg;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_RECORD  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_BAD_SECTION = 2'd1;
   localparam logic [1:0] STAT_BAD_SEQ     = 2'd2;
   localparam logic [1:0] STAT_CONTROL     = 2'd3;

   localparam logic [2:0] SECT_S = 3'd0;
   localparam logic [2:0] SECT_G = 3'd1;
   localparam logic [2:0] SECT_D = 3'd2;
   localparam logic [2:0] SECT_P = 3'd3;
   localparam logic [2:0] SECT_T = 3'd4;
   localparam logic [2:0] SECT_C = 3'd5;

   localparam logic [6:0] LINE_COLUMNS   = 7'd80;
   localparam logic [6:0] SECTION_COLUMN = 7'd72;
   localparam logic [6:0] DATA_LEN_FULL  = 7'd72;
   localparam logic [6:0] DATA_LEN_P     = 7'd64;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CTRL_LAST  = 8'h1F;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_file;
   } lexer_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  data_byte;
      logic [6:0]  column;
      logic [23:0] line_number;
      logic [2:0]  section_code;
      logic [23:0] sequence_number;
      logic [1:0]  status;
      logic [6:0]  data_length;
      logic [15:0] error_count;
      logic        no_start;
   } lexer_rsp_type;

   function automatic logic section_valid(input logic [7:0] b);
      logic v;
      case (b)
         "S", "G", "D", "P", "T", "C": v = 1'b1;
         default:                     v = 1'b0;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] section_code_of(input logic [7:0] b);
      logic [2:0] c;
      case (b)
         "S":     c = SECT_S;
         "G":     c = SECT_G;
         "D":     c = SECT_D;
         "P":     c = SECT_P;
         "T":     c = SECT_T;
         "C":     c = SECT_C;
         default: c = SECT_S;
      endcase
      return c;
   endfunction

endpackage

### hdl/fixed_column_line_lexer.sv
// ----------------------------------------------------------------------------
// Fixed-column line lexer
// Splits an 80-column card-image byte stream into data bytes, line records
// and an end-of-file summary.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  fcll_pkg::lexer_req_type
//   rsp_      out        rsp_valid / rsp_stall  fcll_pkg::lexer_rsp_type
//
// One item per cycle while req_stall is low; its results are registered into the output queue on accept.
// An item yields up to two results, queued in a three-entry output queue;
// req_stall rises while two or more results are waiting.
// Reset (synchronous, active high) empties the queue and clears all counters.
// rsp_stall holds the head result; items keep coming in until two results wait.
// ----------------------------------------------------------------------------
module fixed_column_line_lexer #(
   parameter int LINE_COUNT_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fcll_pkg::lexer_req_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fcll_pkg::lexer_rsp_type rsp_item
);
   import fcll_pkg::*;

   typedef struct packed {
      logic [6:0]  column_count;
      logic        held_cr;
      logic [7:0]  section_byte;
      logic [23:0] seq_acc;
      logic        seq_bad;
      logic        control_seen;
   } line_type;

   localparam line_type LINE_RESET = '{
      column_count: 7'd0, held_cr: 1'b0, section_byte: CHAR_SPACE,
      seq_acc: 24'd0, seq_bad: 1'b0, control_seen: 1'b0};

   line_type                   line_ff, line_in;
   logic [LINE_COUNT_BITS-1:0] lines_ff, lines_in;
   logic                       start_ff, start_in;
   logic [15:0]                rej_ff, rej_in;
   lexer_rsp_type              q_ff [3];
   lexer_rsp_type              q_in [3];
   lexer_rsp_type              shifted [3];
   logic [1:0]                 count_ff, count_in;
   logic [1:0]                 base;
   logic [1:0]                 n_res;
   lexer_rsp_type              res0, res1;
   lexer_rsp_type              rec;
   logic                       accept, pop;

   function automatic logic [23:0] line_out(input logic [LINE_COUNT_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h00FF_FFFF) ? 24'hFF_FFFF : w[23:0];
   endfunction

   assign req_stall = (count_ff > 2'd1);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      line_in  = line_ff;
      lines_in = lines_ff;
      start_in = start_ff;
      rej_in   = rej_ff;
      n_res    = 2'd0;
      res0     = '0;
      res1     = '0;
      rec      = '0;
      if (accept) begin
         if (req_item.end_of_file || req_item.in_byte == CHAR_LF) begin
            if (!req_item.end_of_file || line_in.column_count != 7'd0 || line_in.held_cr) begin
               if (lines_in != '1) begin
                  lines_in = lines_in + LINE_COUNT_BITS'(1);
               end
               if (line_in.column_count != 7'd0) begin
                  rec.result_kind = KIND_RECORD;
                  rec.line_number = line_out(lines_in);
                  if (!section_valid(line_in.section_byte)) begin
                     rec.status      = STAT_BAD_SECTION;
                     rec.data_byte   = line_in.section_byte;
                     rec.data_length = DATA_LEN_FULL;
                     if (rej_in != 16'hFFFF) rej_in = rej_in + 16'd1;
                  end else begin
                     rec.section_code    = section_code_of(line_in.section_byte);
                     rec.data_length     = (rec.section_code == SECT_P) ? DATA_LEN_P
                                                                        : DATA_LEN_FULL;
                     rec.sequence_number = line_in.seq_bad ? 24'd0 : line_in.seq_acc;
                     if (line_in.seq_bad) begin
                        rec.status = STAT_BAD_SEQ;
                        if (rej_in != 16'hFFFF) rej_in = rej_in + 16'd1;
                     end else if (rec.section_code == SECT_S && line_in.control_seen) begin
                        rec.status = STAT_CONTROL;
                        if (rej_in != 16'hFFFF) rej_in = rej_in + 16'd1;
                     end else begin
                        rec.status = STAT_OK;
                        if (rec.section_code == SECT_S) start_in = 1'b1;
                     end
                  end
                  res0  = rec;
                  n_res = 2'd1;
               end
               line_in = LINE_RESET;
            end
            if (req_item.end_of_file) begin
               rec             = '0;
               rec.result_kind = KIND_SUMMARY;
               rec.line_number = line_out(lines_in);
               rec.error_count = rej_in;
               rec.no_start    = !start_in;
               if (n_res == 2'd0) res0 = rec;
               else               res1 = rec;
               n_res    = n_res + 2'd1;
               line_in  = LINE_RESET;
               lines_in = '0;
               start_in = 1'b0;
               rej_in   = 16'd0;
            end
         end else begin
            // release a held carriage return as an ordinary byte
            if (line_in.held_cr) begin
               line_in.held_cr = 1'b0;
               if (line_in.column_count < SECTION_COLUMN) begin
                  res0.result_kind     = KIND_DATA;
                  res0.data_byte       = CHAR_CR;
                  res0.column          = line_in.column_count;
                  n_res                = 2'd1;
                  line_in.control_seen = 1'b1;
               end else if (line_in.column_count == SECTION_COLUMN) begin
                  line_in.section_byte = CHAR_CR;
               end else if (line_in.column_count < LINE_COLUMNS) begin
                  line_in.seq_bad = 1'b1;
               end
               if (line_in.column_count < LINE_COLUMNS) begin
                  line_in.column_count = line_in.column_count + 7'd1;
               end
            end
            if (req_item.in_byte == CHAR_CR) begin
               line_in.held_cr = 1'b1;
            end else begin
               if (line_in.column_count < SECTION_COLUMN) begin
                  rec.result_kind = KIND_DATA;
                  rec.data_byte   = req_item.in_byte;
                  rec.column      = line_in.column_count;
                  if (n_res == 2'd0) res0 = rec;
                  else               res1 = rec;
                  n_res = n_res + 2'd1;
                  if (req_item.in_byte <= CTRL_LAST || req_item.in_byte == CHAR_DEL) begin
                     line_in.control_seen = 1'b1;
                  end
               end else if (line_in.column_count == SECTION_COLUMN) begin
                  line_in.section_byte = req_item.in_byte;
               end else if (line_in.column_count < LINE_COLUMNS) begin
                  if (req_item.in_byte >= CHAR_ZERO && req_item.in_byte <= CHAR_NINE) begin
                     line_in.seq_acc = (line_in.seq_acc << 3) + (line_in.seq_acc << 1)
                                     + 24'(req_item.in_byte[3:0]);
                  end else if (req_item.in_byte != CHAR_SPACE) begin
                     line_in.seq_bad = 1'b1;
                  end
               end
               if (line_in.column_count < LINE_COLUMNS) begin
                  line_in.column_count = line_in.column_count + 7'd1;
               end
            end
         end
      end
   end

   always_comb begin
      shifted[0] = pop ? q_ff[1] : q_ff[0];
      shifted[1] = pop ? q_ff[2] : q_ff[1];
      shifted[2] = q_ff[2];
      base       = count_ff - {1'b0, pop};
      for (int i = 0; i < 3; i++) begin
         q_in[i] = shifted[i];
         if (n_res != 2'd0 && base == 2'(i)) q_in[i] = res0;
         if (n_res == 2'd2 && base + 2'd1 == 2'(i)) q_in[i] = res1;
      end
      count_in = base + n_res;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         count_ff <= 2'd0;
         line_ff  <= LINE_RESET;
         lines_ff <= '0;
         start_ff <= 1'b0;
         rej_ff   <= 16'd0;
      end else begin
         count_ff <= count_in;
         line_ff  <= line_in;
         lines_ff <= lines_in;
         start_ff <= start_in;
         rej_ff   <= rej_in;
      end
   end

endmodule

### hdl/fcll_checker.sv
// ----------------------------------------------------------------------------
// Fixed-column line lexer checker
// Port-level checks on the lexer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_column_line_lexer_assert.svh"

module fcll_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input fcll_pkg::lexer_req_type req_item,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input fcll_pkg::lexer_rsp_type rsp_item
);
   import fcll_pkg::*;

   `FCLL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   `FCLL_ASSERT_NOW(a_stall_backlog, req_stall, rsp_valid)
   `FCLL_ASSERT_NOW(a_data_column, rsp_valid && rsp_item.result_kind == KIND_DATA, rsp_item.column < DATA_LEN_FULL && rsp_item.line_number == 24'd0)
   `FCLL_ASSERT_NOW(a_record_length, rsp_valid && rsp_item.result_kind == KIND_RECORD, (rsp_item.data_length == DATA_LEN_P) == (rsp_item.section_code == SECT_P && rsp_item.status != STAT_BAD_SECTION))
   `FCLL_ASSERT_NOW(a_kind_range, rsp_valid && req_valid && !req_stall && req_item.end_of_file, rsp_item.result_kind == KIND_DATA || rsp_item.result_kind == KIND_RECORD || rsp_item.result_kind == KIND_SUMMARY)

endmodule

bind fixed_column_line_lexer fcll_checker u_fcll_checker (.*);

### tb/tb_fixed_column_line_lexer.sv
// ----------------------------------------------------------------------------
// Fixed-column line lexer testbench
// Feeds card-image byte streams (full cards, short, long and blank lines,
// stray carriage returns, noise and end-of-file marks) under random idling
// on both sides. A scoreboard predicts every data byte, line record and
// summary, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
import fcll_pkg::*;

class lexer_scoreboard;
   lexer_rsp_type expected_q[$];
   int            mismatches;
   int            items;
   int            data_seen;
   int            records_seen;
   int            summaries_seen;

   logic [6:0]    col;
   logic [23:0]   line_cnt;
   bit            held_cr;
   logic [7:0]    sect_byte;
   logic [31:0]   seq_acc;
   bit            seq_bad;
   bit            ctrl_seen;
   bit            start_seen;
   logic [15:0]   rejected;

   function new();
      mismatches     = 0;
      items          = 0;
      data_seen      = 0;
      records_seen   = 0;
      summaries_seen = 0;
      restart_file();
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void queue_result(lexer_rsp_type r);
      expected_q.insert(expected_q.size(), r);
   endfunction

   function void clear_line();
      col       = '0;
      held_cr   = 1'b0;
      sect_byte = CHAR_SPACE;
      seq_acc   = '0;
      seq_bad   = 1'b0;
      ctrl_seen = 1'b0;
   endfunction

   function void restart_file();
      clear_line();
      line_cnt   = '0;
      start_seen = 1'b0;
      rejected   = '0;
   endfunction

   function void count_reject();
      if (rejected != '1) rejected++;
   endfunction

   function void take_byte(logic [7:0] b);
      lexer_rsp_type r;
      if (col < SECTION_COLUMN) begin
         r             = '0;
         r.result_kind = KIND_DATA;
         r.data_byte   = b;
         r.column      = col;
         queue_result(r);
         if (b <= CTRL_LAST || b == CHAR_DEL) ctrl_seen = 1'b1;
      end else if (col == SECTION_COLUMN) begin
         sect_byte = b;
      end else if (col < LINE_COLUMNS) begin
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            seq_acc = seq_acc * 10 + (b - CHAR_ZERO);
         end else if (b != CHAR_SPACE) begin
            seq_bad = 1'b1;
         end
      end
      if (col < LINE_COLUMNS) col++;
   endfunction

   function void close_line();
      lexer_rsp_type r;
      logic [2:0]    code;
      bit            known;
      if (line_cnt != '1) line_cnt++;
      if (col != 0) begin
         r             = '0;
         r.result_kind = KIND_RECORD;
         r.line_number = line_cnt;
         known         = 1'b1;
         code          = SECT_S;
         case (sect_byte)
            "S": code = SECT_S;
            "G": code = SECT_G;
            "D": code = SECT_D;
            "P": code = SECT_P;
            "T": code = SECT_T;
            "C": code = SECT_C;
            default: known = 1'b0;
         endcase
         if (!known) begin
            r.status      = STAT_BAD_SECTION;
            r.data_byte   = sect_byte;
            r.data_length = DATA_LEN_FULL;
            count_reject();
         end else begin
            r.section_code    = code;
            r.data_length     = (code == SECT_P) ? DATA_LEN_P : DATA_LEN_FULL;
            r.sequence_number = seq_bad ? 24'd0 : seq_acc[23:0];
            if (seq_bad) begin
               r.status = STAT_BAD_SEQ;
               count_reject();
            end else if (code == SECT_S && ctrl_seen) begin
               r.status = STAT_CONTROL;
               count_reject();
            end else begin
               r.status = STAT_OK;
               if (code == SECT_S) start_seen = 1'b1;
            end
         end
         queue_result(r);
      end
      clear_line();
   endfunction

   function void note_item(lexer_req_type it);
      lexer_rsp_type r;
      items++;
      if (it.end_of_file) begin
         if (col != 0 || held_cr) close_line();
         r             = '0;
         r.result_kind = KIND_SUMMARY;
         r.line_number = line_cnt;
         r.error_count = rejected;
         r.no_start    = !start_seen;
         queue_result(r);
         restart_file();
      end else if (it.in_byte == CHAR_LF) begin
         close_line();
      end else begin
         if (held_cr) begin
            held_cr = 1'b0;
            take_byte(CHAR_CR);
         end
         if (it.in_byte == CHAR_CR) held_cr = 1'b1;
         else take_byte(it.in_byte);
      end
   endfunction

   function string show(lexer_rsp_type r);
      return $sformatf({"kind=%0d byte=%02h col=%0d line=%0d sect=%0d seq=%0d",
                        " stat=%0d len=%0d err=%0d nostart=%0d"},
                       r.result_kind, r.data_byte, r.column, r.line_number,
                       r.section_code, r.sequence_number, r.status, r.data_length,
                       r.error_count, r.no_start);
   endfunction

   function void check_result(lexer_rsp_type got);
      lexer_rsp_type want;
      string         diff;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: result with none expected: %s", show(got));
         end
         return;
      end
      want = expected_q.pop_front();
      diff = "";
      if (got.result_kind !== want.result_kind) diff = {diff, " result_kind"};
      if (got.data_byte !== want.data_byte) diff = {diff, " data_byte"};
      if (got.column !== want.column) diff = {diff, " column"};
      if (got.line_number !== want.line_number) diff = {diff, " line_number"};
      if (got.section_code !== want.section_code) diff = {diff, " section_code"};
      if (got.sequence_number !== want.sequence_number) diff = {diff, " sequence_number"};
      if (got.status !== want.status) diff = {diff, " status"};
      if (got.data_length !== want.data_length) diff = {diff, " data_length"};
      if (got.error_count !== want.error_count) diff = {diff, " error_count"};
      if (got.no_start !== want.no_start) diff = {diff, " no_start"};
      if (diff != "") begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: mismatch in%s", diff);
            $display("   expected %s", show(want));
            $display("   actual   %s", show(got));
         end
      end else begin
         case (want.result_kind)
            KIND_DATA:   data_seen++;
            KIND_RECORD: records_seen++;
            default:     summaries_seen++;
         endcase
      end
   endfunction
endclass

module tb_fixed_column_line_lexer;

   localparam int RANDOM_ITEMS = 1500;
   localparam int QUIET_FROM   = 1250;
   localparam int HOLD_AT      = 400;
   localparam int DRAIN_AT     = 800;
   localparam int HOLD_CYCLES  = 180;
   localparam int LIMIT_CYCLES = 400000;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   lexer_req_type req_item  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   lexer_rsp_type rsp_item;

   lexer_scoreboard sb = new();

   int cycles     = 0;
   int sent       = 0;
   int gap_rate   = 0;
   int rsp_rate   = 0;
   int stall_left = 0;
   bit quiet      = 1'b0;
   bit hold_req   = 1'b0;

   fixed_column_line_lexer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.pending());
         $display("tb_fixed_column_line_lexer NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_item);
         if (req_valid && !req_stall) sb.note_item(req_item);
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (hold_req) begin
         stall_left = HOLD_CYCLES;
         hold_req   = 1'b0;
      end else if (!quiet && rsp_rate != 0 && $urandom_range(1, rsp_rate) == 1) begin
         stall_left = $urandom_range(1, 13);
      end
      rsp_stall = (stall_left != 0);
   end

   function automatic int pick_rate();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         2:       return 6;
         default: return 14;
      endcase
   endfunction

   function automatic logic [7:0] pick_data(input bit clean);
      logic [7:0] b;
      if (clean) return 8'($urandom_range(8'h20, 8'h7E));
      case ($urandom_range(0, 19))
         16, 17:  b = 8'($urandom_range(0, 255));
         18:      b = 8'($urandom_range(0, CTRL_LAST));
         19:      b = CHAR_DEL;
         default: b = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      if (b == CHAR_LF) b = CHAR_SPACE;
      return b;
   endfunction

   task automatic send_item(input lexer_req_type it);
      if (!quiet && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_item  = it;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      lexer_req_type it;
      it.in_byte     = b;
      it.end_of_file = 1'b0;
      send_item(it);
   endtask

   task automatic send_eof();
      lexer_req_type it;
      it.in_byte     = 8'($urandom_range(0, 255));
      it.end_of_file = 1'b1;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // full card: 72 data columns, section letter, sequence field, optional overrun
   task automatic send_card(input int extra);
      logic [7:0] seq_txt [0:6];
      logic [7:0] b;
      int         v;
      int         i;
      int         cols;
      bit         clean;
      v = $urandom_range(0, 9999999);
      for (i = 6; i >= 0; i--) begin
         seq_txt[i] = (i == 6 || v != 0) ? 8'(CHAR_ZERO + v % 10) : CHAR_SPACE;
         v = v / 10;
      end
      case ($urandom_range(0, 9))
         0: seq_txt[$urandom_range(0, 6)] = CHAR_SPACE;
         1: begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SPACE || b == CHAR_LF);
            seq_txt[$urandom_range(0, 6)] = b;
         end
         2: for (i = 0; i < 7; i++) seq_txt[i] = CHAR_SPACE;
         default: ;
      endcase
      cols  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 7;
      clean = ($urandom_range(0, 9) < 6);
      for (i = 0; i < 72; i++) send_byte(pick_data(clean));
      case ($urandom_range(0, 9))
         0, 1, 8: b = "S";
         2:       b = "G";
         3:       b = "D";
         4, 9:    b = "P";
         5:       b = "T";
         6:       b = "C";
         default: begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_LF) b = CHAR_SPACE;
         end
      endcase
      send_byte(b);
      for (i = 0; i < cols; i++) send_byte(seq_txt[i]);
      for (i = 0; i < extra; i++) send_byte(pick_data(1'b0));
      if ($urandom_range(0, 1)) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   initial begin
      int directed;
      int done;
      int phase_mark;
      int shape;
      int n;
      int i;
      bit hold_done;
      bit drain_done;
      int failures;

      hold_done  = 1'b0;
      drain_done = 1'b0;
      phase_mark = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty file, blank line, line holding only a carriage return
      send_eof();
      send_byte(CHAR_LF);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      // extreme bytes, released and stripped carriage returns, short line
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_DEL);
      send_byte(CTRL_LAST);
      send_byte(8'h80);
      send_byte(CHAR_SPACE);
      send_byte(CHAR_CR);
      send_byte(8'h41);
      send_byte(CHAR_CR);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      // end of file flushing an open line with a held carriage return
      send_byte("S");
      send_byte(CHAR_CR);
      send_eof();
      send_byte(CHAR_CR);
      send_eof();
      send_eof();
      directed = sent;

      while (sent - directed < RANDOM_ITEMS) begin
         done = sent - directed;
         if (done >= phase_mark) begin
            gap_rate   = pick_rate();
            rsp_rate   = pick_rate();
            phase_mark = phase_mark + 150;
         end
         if (done >= QUIET_FROM) quiet = 1'b1;
         if (!hold_done && done >= HOLD_AT) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && done >= DRAIN_AT) begin
            wait_drained();
            drain_done = 1'b1;
         end
         shape = $urandom_range(0, 99);
         if (shape < 50) begin
            send_card(0);
         end else if (shape < 62) begin
            n = $urandom_range(1, 40);
            for (i = 0; i < n; i++) send_byte(pick_data(1'b0));
            if ($urandom_range(0, 1)) send_byte(CHAR_CR);
            send_byte(CHAR_LF);
         end else if (shape < 70) begin
            if ($urandom_range(0, 1)) send_byte(CHAR_CR);
            send_byte(CHAR_LF);
         end else if (shape < 80) begin
            send_card($urandom_range(1, 12));
         end else if (shape < 88) begin
            send_eof();
         end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
         end
      end
      send_eof();

      wait_drained();
      repeat (20) @(negedge clock);
      failures = sb.mismatches + sb.pending();
      if (sb.pending() != 0) begin
         $display("ERROR: %0d expected results never arrived", sb.pending());
      end
      $display("Covered %0d items in, %0d data bytes, %0d line records, %0d summaries out",
               sb.items, sb.data_seen, sb.records_seen, sb.summaries_seen);
      $display("Mismatches: %0d", sb.mismatches);
      if (failures == 0) begin
         $display("tb_fixed_column_line_lexer OK");
      end else begin
         $display("tb_fixed_column_line_lexer NOT OK");
      end
      $finish;
   end

endmodule

### fixed_column_line_lexer.f
+incdir+hdl
hdl/fcll_pkg.sv
hdl/fixed_column_line_lexer.sv
hdl/fcll_checker.sv
tb/tb_fixed_column_line_lexer.sv
